@@ hw/rtl/rpwf_pkg.sv @@
// Shared codes and widths of the packet reorder window.
// No dependencies; imported by the top level and the port checker.
package rpwf_pkg;

  localparam int WIN_W   = 8;
  localparam int FMS_W   = 16;
  localparam int CFG_W   = 16;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 8;
  localparam int LCNT_W  = 9;
  localparam int FLUSH_W = 32;

  localparam logic [WIN_W-1:0] WIN_RESET = 8'd8;
  localparam logic [FMS_W-1:0] FMS_RESET = 16'd50;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_FLUSH  = 1'b1;

  localparam logic [1:0] MODE_ARRIVE = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [1:0] SLOT_RECEIVED = 2'd1;
  localparam logic [1:0] SLOT_EMITTED  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OLD      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_TICK     = 3'd5;

endpackage

@@ hw/rtl/packet_reorder_window_flush.sv @@
// Top level of the receive-side packet reorder window with timed flush.
// Depends on rpwf_pkg and rpwf_mod; holds the slot ring memory and sequencer.
//
// Usage: items enter on in_valid/in_ready with mode, seq and time_ms. Mode
// arrive stores a packet (or reports it too old or duplicate) and returns
// the ring slot for the payload buffer; mode pop releases the next packet in
// order; mode tick records the time and flushes leading gaps in front of a
// packet that has waited flush_ms. Exactly one result per item leaves on
// out_valid/out_ready. Configuration writes (cfg_we, cfg_index, cfg_data)
// must be made while the block is idle; the block itself does not enforce it.
// Flow: one item at a time. Arrive, pop and tick run the bit-serial ring
// index unit (pop and tick pass a prep state first), then visit ring slots,
// each with a memory read, then a modify and write back;
// stamping and popping may visit up to the ring length, and a tick's
// look-ahead adds up to another ring length. Old arrivals and unused modes
// skip the index unit and go straight to the result.
// Reset: a clearing pass over all RING_DEPTH slots empties the ring, with
// in_ready low. A held result does not block the next item; the block only
// waits at the end of an item while the previous result is still not taken.
module packet_reorder_window_flush
  import rpwf_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int SEQ_BITS   = 56,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [SEQ_BITS-1:0]  seq,
  input  logic [TIME_BITS-1:0] time_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    status,
  output logic [SEQ_BITS-1:0]  out_seq,
  output logic [SLOT_W-1:0]    slot_index,
  output logic [SEQ_BITS-1:0]  lost_first_seq,
  output logic [LCNT_W-1:0]    lost_count,
  output logic [FLUSH_W-1:0]   flush_total,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RW = $clog2(RING_DEPTH) + 1;
  localparam int NW = SEQ_BITS + 1;
  localparam int EW = SEQ_BITS + 2;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           state;
    logic [TIME_BITS-1:0] tm;
    logic [SEQ_BITS-1:0]  sq;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_MODGO, S_MOD, S_RD, S_EX, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_STAMP, PH_STORE, PH_POP, PH_TICK, PH_LOOK
  } phase_t;

  state_t state;
  phase_t phase;

  entry_t mem [RING_DEPTH];
  entry_t rd;
  entry_t wd;
  logic   we;
  logic [IW-1:0] wa;
  logic [IW-1:0] ra;

  logic [WIN_W-1:0]     win;
  logic [FMS_W-1:0]     fms;
  logic [SEQ_BITS-1:0]  highest;
  logic [NW-1:0]        nr;
  logic                 started;
  logic [TIME_BITS-1:0] last_tick;
  logic [FLUSH_W-1:0]   flush_counter;

  logic [IW-1:0]       clr_idx;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       jdx;
  logic [NW-1:0]       cur;
  logic [SEQ_BITS-1:0] s_reg;
  logic                due_hit;
  logic [NW-1:0]       due_pos;

  logic [STAT_W-1:0]   r_status;
  logic [SEQ_BITS-1:0] r_seq;
  logic [IW-1:0]       r_slot;
  logic [SEQ_BITS-1:0] r_lfirst;
  logic [LCNT_W-1:0]   r_lcnt;

  logic [WIN_W-1:0] w_eff;
  logic [9:0]       r2;
  logic [RW-1:0]    rlen;

  always_comb begin
    w_eff = (win == '0) ? WIN_W'(1) : win;
    r2    = {1'b0, w_eff, 1'b0};
    if (32'(r2) > 32'(RING_DEPTH)) begin
      rlen = RW'(RING_DEPTH / 2 * 2);
    end else begin
      rlen = RW'(r2);
    end
  end

  logic [EW-1:0] nr_plus_r;
  logic [EW-1:0] hi_ext;
  logic          far;
  logic [NW-1:0] first;
  logic [NW-1:0] s_ext;
  logic [NW-1:0] s_plus1;
  logic [NW-1:0] st0;
  logic [NW-1:0] lowb;
  logic [NW-1:0] stamp_start;
  logic          do_stamp;
  logic          is_old;
  logic          look_ok;
  logic          overdue;

  always_comb begin
    nr_plus_r = EW'(nr) + EW'(rlen);
    hi_ext    = EW'(highest);
    far       = started && (nr_plus_r <= hi_ext);
    first     = NW'(highest) - NW'(rlen) + NW'(1);
    s_ext     = NW'(seq);
    s_plus1   = s_ext + NW'(1);
    st0       = started ? (NW'(highest) + NW'(1)) : '0;
    lowb      = s_plus1 - NW'(rlen);
    if ((s_plus1 >= NW'(rlen)) && (st0 < lowb)) begin
      stamp_start = lowb;
    end else begin
      stamp_start = st0;
    end
    do_stamp = !started || (seq > highest);
    is_old   = (EW'(seq) + EW'(rlen)) <= hi_ext;
    look_ok  = (cur <= NW'(highest)) && (EW'(cur) < nr_plus_r);
    overdue  = (last_tick >= rd.tm) && ((last_tick - rd.tm) >= TIME_BITS'(fms));
  end

  logic          mod_start;
  logic          mod_done;
  logic [RW-1:0] mod_rem;
  logic [NW-1:0] mod_dvd;

  assign mod_start = (state == S_MODGO);
  assign mod_dvd   = ((phase == PH_POP) || (phase == PH_TICK)) ? nr : cur;

  rpwf_mod #(.DW(NW), .RW(RW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (rlen),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i, input logic [RW-1:0] r);
    wrap_inc = ((RW'(i) + RW'(1)) >= r) ? '0 : (i + IW'(1));
  endfunction

  logic [NW-1:0] key;
  logic          hit;

  always_comb begin
    key = ((phase == PH_POP) || (phase == PH_TICK)) ? nr : cur;
    hit = rd.valid && ({1'b0, rd.sq} == key);
    ra  = (phase == PH_LOOK) ? jdx : idx;
  end

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr_idx;
    end else if (state == S_EX) begin
      unique case (phase)
        PH_STAMP: begin
          if (!(hit && (rd.state != SLOT_EMPTY))) begin
            we       = 1'b1;
            wd.valid = 1'b1;
            wd.state = SLOT_EMPTY;
            wd.sq    = cur[SEQ_BITS-1:0];
          end
        end
        PH_STORE: begin
          if (!(hit && (rd.state != SLOT_EMPTY))) begin
            we       = 1'b1;
            wd.valid = 1'b1;
            wd.state = SLOT_RECEIVED;
            wd.tm    = last_tick;
            wd.sq    = cur[SEQ_BITS-1:0];
          end
        end
        PH_POP: begin
          if (hit && (rd.state == SLOT_RECEIVED)) begin
            we       = 1'b1;
            wd       = rd;
            wd.state = SLOT_EMITTED;
          end
        end
        PH_TICK, PH_LOOK: begin
          we = 1'b0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      phase         <= PH_STORE;
      clr_idx       <= '0;
      win           <= WIN_RESET;
      fms           <= FMS_RESET;
      highest       <= '0;
      nr            <= '0;
      started       <= 1'b0;
      last_tick     <= '0;
      flush_counter <= '0;
      due_hit       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW: win <= cfg_data[WIN_W-1:0];
          CFG_FLUSH:  fms <= cfg_data[FMS_W-1:0];
        endcase
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (32'(clr_idx) == RING_DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            r_seq    <= '0;
            r_slot   <= '0;
            r_lfirst <= '0;
            r_lcnt   <= '0;
            s_reg    <= seq;
            unique case (mode)
              MODE_ARRIVE: begin
                if (do_stamp) begin
                  r_status <= STAT_NONE;
                  cur      <= stamp_start;
                  phase    <= PH_STAMP;
                  state    <= S_MODGO;
                end else if (is_old) begin
                  r_status <= STAT_OLD;
                  state    <= S_DONE;
                end else begin
                  r_status <= STAT_NONE;
                  cur      <= s_ext;
                  phase    <= PH_STORE;
                  state    <= S_MODGO;
                end
              end
              MODE_POP: begin
                r_status <= STAT_NONE;
                if (far) begin
                  flush_counter <= flush_counter + FLUSH_W'(first - nr);
                  nr            <= first;
                end
                phase <= PH_POP;
                state <= S_PREP;
              end
              MODE_TICK: begin
                last_tick <= time_ms;
                r_status  <= STAT_TICK;
                due_hit   <= 1'b0;
                if (far) begin
                  nr <= first;
                end
                phase <= PH_TICK;
                state <= S_PREP;
              end
              default: begin
                r_status <= STAT_NONE;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_PREP: begin
          if (!started || (nr > NW'(highest))) begin
            state <= S_DONE;
          end else begin
            state <= S_MODGO;
          end
        end
        S_MODGO: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            idx   <= mod_rem[IW-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          priority if ((phase == PH_POP) || (phase == PH_TICK)) begin
            state <= (nr > NW'(highest)) ? S_DONE : S_EX;
          end else if (phase == PH_LOOK) begin
            state <= look_ok ? S_EX : S_DONE;
          end else begin
            state <= S_EX;
          end
        end
        S_EX: begin
          unique case (phase)
            PH_STAMP: begin
              if (!(hit && (rd.state != SLOT_EMPTY)) && rd.valid && !hit &&
                  (rd.state == SLOT_RECEIVED) && (NW'(rd.sq) >= nr)) begin
                flush_counter <= flush_counter + FLUSH_W'(1);
              end
              if (cur == NW'(s_reg)) begin
                highest <= s_reg;
                started <= 1'b1;
                phase   <= PH_STORE;
              end else begin
                cur <= cur + NW'(1);
                idx <= wrap_inc(idx, rlen);
              end
              state <= S_RD;
            end
            PH_STORE: begin
              if (hit && (rd.state != SLOT_EMPTY)) begin
                r_status <= STAT_DUP;
              end else begin
                r_status <= STAT_STORED;
                r_slot   <= idx;
              end
              state <= S_DONE;
            end
            PH_POP: begin
              if (!hit) begin
                flush_counter <= flush_counter + FLUSH_W'(1);
                nr            <= nr + NW'(1);
                idx           <= wrap_inc(idx, rlen);
                state         <= S_RD;
              end else if (rd.state == SLOT_EMPTY) begin
                state <= S_DONE;
              end else if (rd.state == SLOT_EMITTED) begin
                nr    <= nr + NW'(1);
                idx   <= wrap_inc(idx, rlen);
                state <= S_RD;
              end else begin
                r_status <= STAT_RELEASED;
                r_seq    <= nr[SEQ_BITS-1:0];
                r_slot   <= idx;
                nr       <= nr + NW'(1);
                state    <= S_DONE;
              end
            end
            PH_TICK: begin
              if (!hit || (rd.state == SLOT_EMITTED)) begin
                nr    <= nr + NW'(1);
                idx   <= wrap_inc(idx, rlen);
                state <= S_RD;
              end else if (rd.state != SLOT_EMPTY) begin
                state <= S_DONE;
              end else if (due_hit && (due_pos > nr)) begin
                flush_counter <= flush_counter + FLUSH_W'(1);
                if (r_lcnt == '0) begin
                  r_lfirst <= nr[SEQ_BITS-1:0];
                end
                r_lcnt <= r_lcnt + LCNT_W'(1);
                nr     <= nr + NW'(1);
                idx    <= wrap_inc(idx, rlen);
                state  <= S_RD;
              end else begin
                cur   <= nr + NW'(1);
                jdx   <= wrap_inc(idx, rlen);
                phase <= PH_LOOK;
                state <= S_RD;
              end
            end
            PH_LOOK: begin
              if (hit && (rd.state == SLOT_RECEIVED) && overdue) begin
                due_hit       <= 1'b1;
                due_pos       <= cur;
                flush_counter <= flush_counter + FLUSH_W'(1);
                if (r_lcnt == '0) begin
                  r_lfirst <= nr[SEQ_BITS-1:0];
                end
                r_lcnt <= r_lcnt + LCNT_W'(1);
                nr     <= nr + NW'(1);
                idx    <= wrap_inc(idx, rlen);
                phase  <= PH_TICK;
              end else begin
                cur <= cur + NW'(1);
                jdx <= wrap_inc(jdx, rlen);
              end
              state <= S_RD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= r_status;
            out_seq        <= r_seq;
            slot_index     <= SLOT_W'(r_slot);
            lost_first_seq <= r_lfirst;
            lost_count     <= r_lcnt;
            flush_total    <= flush_counter;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/rpwf_mod.sv @@
// Bit-serial remainder unit: dividend modulo a small ring length.
// Standalone; one dividend bit per cycle, used by the reorder window top level.
module rpwf_mod #(
  parameter int DW = 57,
  parameter int RW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [RW:0]   trial;

  assign trial = {rem, dvd[DW-1]};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
      dvd  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CW'(1);
        dvd <= {dvd[DW-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= RW'(trial - {1'b0, divisor});
        end else begin
          rem <= RW'(trial);
        end
      end
    end
  end

endmodule

@@ hw/rtl/rpwf_checker.sv @@
// Port checker for the packet reorder window, bound to its top level.
// Depends on rpwf_pkg; observes the top level's ports only.
module rpwf_checker
  import rpwf_pkg::*;
#(
  parameter int SEQ_BITS = 56
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STAT_W-1:0]   status,
  input logic [SEQ_BITS-1:0] out_seq,
  input logic [SLOT_W-1:0]   slot_index,
  input logic [SEQ_BITS-1:0] lost_first_seq,
  input logic [LCNT_W-1:0]   lost_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_seq))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= STAT_TICK))
    else $error("status code out of range");

  a_slot_only_store_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_STORED) && (status != STAT_RELEASED)
      |-> (slot_index == '0) && (out_seq == '0))
    else $error("slot or sequence reported without store or release");

  a_loss_only_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_TICK) |-> (lost_count == '0) && (lost_first_seq == '0))
    else $error("loss reported outside a tick");

endmodule

bind packet_reorder_window_flush rpwf_checker #(.SEQ_BITS(SEQ_BITS)) u_rpwf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .out_seq        (out_seq),
  .slot_index     (slot_index),
  .lost_first_seq (lost_first_seq),
  .lost_count     (lost_count)
);
